[rtl/att_pkg.sv]
// ----------------------------------------------------------------------------
// att_pkg: shared types and constants of the ansi text terminal
// parse modes, character codes, controller states and commands, datapath status
// ----------------------------------------------------------------------------
package att_pkg;

  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int ADDR_IN_W = 11;
  localparam int CELL_W = 16;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_A       = 8'h41;
  localparam logic [7:0] CH_B       = 8'h42;
  localparam logic [7:0] CH_C       = 8'h43;
  localparam logic [7:0] CH_D       = 8'h44;
  localparam logic [7:0] CH_E       = 8'h45;
  localparam logic [7:0] CH_F       = 8'h46;
  localparam logic [7:0] CH_H       = 8'h48;
  localparam logic [7:0] CH_J       = 8'h4A;
  localparam logic [7:0] CH_K       = 8'h4B;
  localparam logic [7:0] CH_S_LOWER = 8'h73;
  localparam logic [7:0] CH_U_LOWER = 8'h75;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_CSI    = 3'd2,
    MODE_FIRST  = 3'd3,
    MODE_SECOND = 3'd4
  } parse_mode_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic fill_blank;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic erase_start;
    logic sweep_last;
    logic out_free;
  } dp_status_t;

endpackage

[rtl/att_ctrl.sv]
// ----------------------------------------------------------------------------
// att_ctrl: sequencer of the ansi text terminal
// steps each item through capture, execute, optional clear sweep and result
// ----------------------------------------------------------------------------
module att_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  att_pkg::dp_status_t status,
  output att_pkg::ctrl_cmd_t  cmd
);

  att_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= att_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      att_pkg::ST_INIT: begin
        if (status.sweep_last) state_next = att_pkg::ST_IDLE;
      end
      att_pkg::ST_IDLE: begin
        if (in_valid) state_next = att_pkg::ST_EXEC;
      end
      att_pkg::ST_EXEC: begin
        state_next = status.erase_start ? att_pkg::ST_CLEAR : att_pkg::ST_DONE;
      end
      att_pkg::ST_CLEAR: begin
        if (status.sweep_last) state_next = att_pkg::ST_DONE;
      end
      att_pkg::ST_DONE: begin
        if (status.out_free) state_next = att_pkg::ST_IDLE;
      end
      default: state_next = att_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      att_pkg::ST_INIT: begin
        cmd.sweep      = 1'b1;
        cmd.fill_blank = 1'b1;
      end
      att_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      att_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      att_pkg::ST_CLEAR: begin
        cmd.sweep = 1'b1;
      end
      att_pkg::ST_DONE: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/att_datapath.sv]
// ----------------------------------------------------------------------------
// att_datapath: cursor, escape parser registers, cell store and result register
// applies one item per execute command and sweeps cleared spans one cell a cycle
// ----------------------------------------------------------------------------
module att_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                             clk,
  input  logic                             rst,
  input  att_pkg::ctrl_cmd_t               cmd,
  output att_pkg::dp_status_t              status,
  input  logic                             cfg_write,
  input  logic [7:0]                       cfg_data,
  input  logic                             action,
  input  logic [7:0]                       char_code,
  input  logic [att_pkg::ADDR_IN_W-1:0]    cell_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [att_pkg::CELL_W-1:0]       cell_data,
  output logic [att_pkg::ROW_W-1:0]        cursor_row,
  output logic [att_pkg::COL_W-1:0]        cursor_col
);

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = att_pkg::ROW_W;
  localparam int COL_W  = att_pkg::COL_W;

  // saturating decimal accumulate
  function automatic logic [7:0] accumulate(input logic [7:0] acc, input logic [3:0] digit);
    logic [11:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {8'h00, digit};
    return (v > 12'd255) ? 8'hFF : v[7:0];
  endfunction

  logic [att_pkg::CELL_W-1:0] mem [CELLS];

  logic                        item_action;
  logic [7:0]                  item_char;
  logic [att_pkg::ADDR_IN_W-1:0] item_addr;

  logic [7:0]          text_color;
  logic [ROW_W-1:0]    row, row_next;
  logic [COL_W-1:0]    col, col_next;
  logic [ROW_W-1:0]    mark_row, mark_row_next;
  logic [COL_W-1:0]    mark_col, mark_col_next;
  att_pkg::parse_mode_t mode, mode_next;
  logic [7:0]          first_num, first_num_next;
  logic [7:0]          second_num, second_num_next;

  logic [ADDR_W-1:0]   ptr, sweep_end;
  logic [ADDR_W-1:0]   span_from, span_to;
  logic                erase_go;
  logic                cell_we;

  logic [att_pkg::CELL_W-1:0] rdata;
  logic                rd_ok;
  logic                in_range;

  logic [ADDR_W-1:0]   here, row_start, row_end;
  logic [7:0]          c;
  logic                is_digit, is_mover;
  logic [7:0]          mv_n, er_n;
  logic [8:0]          down_sum, right_sum;
  logic [ROW_W-1:0]    up_row, down_row;
  logic [COL_W-1:0]    left_col, right_col;
  logic [7:0]          h_row, h_col;
  logic [COL_W:0]      col_inc;

  assign c         = item_char;
  assign is_digit  = (c >= att_pkg::CH_ZERO) && (c <= att_pkg::CH_NINE);
  assign is_mover  = (c >= att_pkg::CH_A) && (c <= att_pkg::CH_F);
  assign here      = ADDR_W'(32'(row) * COLUMNS + 32'(col));
  assign row_start = ADDR_W'(32'(row) * COLUMNS);
  assign row_end   = ADDR_W'(32'(row) * COLUMNS + COLUMNS - 1);
  assign in_range  = 32'(item_addr) < 32'(CELLS);

  // cursor moves, count of zero means one
  assign mv_n      = (mode == att_pkg::MODE_CSI || first_num == 8'd0) ? 8'd1 : first_num;
  assign er_n      = (mode == att_pkg::MODE_CSI) ? 8'd0 : first_num;
  assign up_row    = (9'(row) > 9'(mv_n)) ? row - ROW_W'(mv_n) : '0;
  assign down_sum  = 9'(row) + 9'(mv_n);
  assign down_row  = (down_sum >= 9'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(down_sum);
  assign left_col  = (9'(col) > 9'(mv_n)) ? col - COL_W'(mv_n) : '0;
  assign right_sum = 9'(col) + 9'(mv_n);
  assign right_col = (right_sum >= 9'(COLUMNS)) ? COL_W'(COLUMNS - 1) : COL_W'(right_sum);
  assign h_row     = (first_num == 8'd0) ? 8'd0 : first_num - 8'd1;
  assign h_col     = (second_num == 8'd0) ? 8'd0 : second_num - 8'd1;
  assign col_inc   = (c == att_pkg::CH_NEWLINE) ? (COL_W+1)'(COLUMNS) : {1'b0, col} + 1'b1;

  always_comb begin
    row_next        = row;
    col_next        = col;
    mark_row_next   = mark_row;
    mark_col_next   = mark_col;
    mode_next       = mode;
    first_num_next  = first_num;
    second_num_next = second_num;
    cell_we         = 1'b0;
    erase_go        = 1'b0;
    span_from       = here;
    span_to         = here;
    unique case (mode)
      att_pkg::MODE_ESC: begin
        mode_next = (c == att_pkg::CH_LBRACK) ? att_pkg::MODE_CSI : att_pkg::MODE_NORMAL;
      end
      att_pkg::MODE_CSI, att_pkg::MODE_FIRST: begin
        mode_next = att_pkg::MODE_NORMAL;
        priority if (is_mover) begin
          if (c == att_pkg::CH_A || c == att_pkg::CH_F) row_next = up_row;
          if (c == att_pkg::CH_B || c == att_pkg::CH_E) row_next = down_row;
          if (c == att_pkg::CH_C) col_next = right_col;
          if (c == att_pkg::CH_D) col_next = left_col;
          if (c == att_pkg::CH_E || c == att_pkg::CH_F) col_next = '0;
        end else if (c == att_pkg::CH_J) begin
          erase_go = (er_n <= 8'd2);
          span_from = (er_n == 8'd0) ? here : '0;
          span_to   = (er_n == 8'd1) ? here : ADDR_W'(CELLS - 1);
        end else if (c == att_pkg::CH_K) begin
          erase_go = (er_n <= 8'd2);
          span_from = (er_n == 8'd0) ? here : row_start;
          span_to   = (er_n == 8'd1) ? here : row_end;
        end else if (is_digit) begin
          first_num_next = (mode == att_pkg::MODE_CSI) ? {4'h0, c[3:0]}
                                                       : accumulate(first_num, c[3:0]);
          mode_next = att_pkg::MODE_FIRST;
        end else if (c == att_pkg::CH_SEMI) begin
          second_num_next = 8'd0;
          mode_next = att_pkg::MODE_SECOND;
        end else if (mode == att_pkg::MODE_CSI && c == att_pkg::CH_S_LOWER) begin
          mark_row_next = row;
          mark_col_next = col;
        end else if (mode == att_pkg::MODE_CSI && c == att_pkg::CH_U_LOWER) begin
          row_next = mark_row;
          col_next = mark_col;
        end else begin
          mode_next = att_pkg::MODE_NORMAL;
        end
      end
      att_pkg::MODE_SECOND: begin
        if (is_digit) begin
          second_num_next = accumulate(second_num, c[3:0]);
        end else begin
          if (c == att_pkg::CH_H) begin
            row_next = (32'(h_row) >= 32'(ROWS)) ? ROW_W'(ROWS - 1) : ROW_W'(h_row);
            col_next = (32'(h_col) >= 32'(COLUMNS)) ? COL_W'(COLUMNS - 1) : COL_W'(h_col);
          end
          mode_next = att_pkg::MODE_NORMAL;
        end
      end
      default: begin
        mode_next      = att_pkg::MODE_NORMAL;
        first_num_next = 8'd0;
        if (c == att_pkg::CH_ESC) begin
          mode_next = att_pkg::MODE_ESC;
        end else begin
          cell_we = (c != att_pkg::CH_NEWLINE);
          if (col_inc >= (COL_W+1)'(COLUMNS)) begin
            col_next = '0;
            row_next = (32'(row) == ROWS - 1) ? '0 : row + 1'b1;
          end else begin
            col_next = col_inc[COL_W-1:0];
          end
        end
      end
    endcase
  end

  assign status.erase_start = ~item_action & erase_go;
  assign status.sweep_last  = (ptr == sweep_end);
  assign status.out_free    = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_action <= action;
      item_char   <= char_code;
      item_addr   <= cell_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= att_pkg::TEXT_COLOR_RESET;
      row        <= '0;
      col        <= '0;
      mark_row   <= '0;
      mark_col   <= '0;
      mode       <= att_pkg::MODE_NORMAL;
      first_num  <= '0;
      second_num <= '0;
      ptr        <= '0;
      sweep_end  <= ADDR_W'(CELLS - 1);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) text_color <= cfg_data;
      if (cmd.exec && !item_action) begin
        row        <= row_next;
        col        <= col_next;
        mark_row   <= mark_row_next;
        mark_col   <= mark_col_next;
        mode       <= mode_next;
        first_num  <= first_num_next;
        second_num <= second_num_next;
      end
      if (cmd.exec && status.erase_start) begin
        ptr       <= span_from;
        sweep_end <= span_to;
      end else if (cmd.sweep) begin
        ptr <= ptr + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // single write port shared by the sweep and character stores
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      mem[ptr] <= cmd.fill_blank ? att_pkg::BLANK_CELL : {text_color, att_pkg::CH_SPACE};
    end else if (cmd.exec && !item_action && cell_we) begin
      mem[here] <= {text_color, item_char};
    end
    if (cmd.exec && item_action && in_range) begin
      rdata <= mem[ADDR_W'(item_addr)];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) rd_ok <= item_action & in_range;
    if (cmd.load_out) begin
      cell_data  <= rd_ok ? rdata : '0;
      cursor_row <= row;
      cursor_col <= col;
    end
  end

endmodule

[rtl/ansi_text_terminal.sv]
// ----------------------------------------------------------------------------
// ansi_text_terminal: text-mode character terminal with an escape parser
// feeds bytes through an ESC [ parser into a cell store, reads cells back
// ----------------------------------------------------------------------------
// After reset the block first blanks its ROWS*COLUMNS cell store to 0x0720,
// one cell per cycle, and takes no item during that pass; text_color writes
// are taken at any time. Then each item steps through capture, execute
// against the cursor and parser registers (and the one-port cell store) and
// load of the result register, which waits until that register is free. An
// erase command (J or K) adds a sweep of the cleared cells, one at a time
// through the single write port of the cell store: up to all ROWS*COLUMNS
// cells for a full-screen erase, COLUMNS cells for a full-row erase. One
// item is in flight at a time; the next input transfer is taken as soon as
// the result register has been loaded, even while that result still waits.
// ----------------------------------------------------------------------------
module ansi_text_terminal #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: text attribute register
  input  logic                          cfg_write,
  input  logic [7:0]                    cfg_data,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          action,
  input  logic [7:0]                    char_code,
  input  logic [att_pkg::ADDR_IN_W-1:0] cell_address,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [att_pkg::CELL_W-1:0]    cell_data,
  output logic [att_pkg::ROW_W-1:0]     cursor_row,
  output logic [att_pkg::COL_W-1:0]     cursor_col
);

  // command and status between sequencer and datapath
  att_pkg::ctrl_cmd_t  cmd;
  att_pkg::dp_status_t status;

  // sequencer: init sweep, idle, execute, clear sweep, result
  att_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: parser state, cursor, cell store, result register
  att_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .action       (action),
    .char_code    (char_code),
    .cell_address (cell_address),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cell_data    (cell_data),
    .cursor_row   (cursor_row),
    .cursor_col   (cursor_col)
  );

endmodule
